[src/selective_ack_send_window_defines.svh]
// ----------------------------------------------------------------------------
// Selective ack send window: assertion macros
// Shared clocked assertion macros; they are empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_ACK_SEND_WINDOW_DEFINES_SVH
`define SELECTIVE_ACK_SEND_WINDOW_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define SASW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sasw: assertion failed");
// condition must never be seen at a clock edge out of reset
`define SASW_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("sasw: forbidden condition");
`else
`define SASW_ASSERT(lbl, prop)
`define SASW_NEVER(lbl, expr)
`endif
`endif

[src/sasw_pkg.sv]
// ----------------------------------------------------------------------------
// Selective ack send window package
// Widths, codes, sequencer states and the modulo step shared by several files.
// ----------------------------------------------------------------------------
`default_nettype none

package sasw_pkg;

  localparam int WINDOW_MAX = 16;
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int ID_W       = 64;
  localparam int LEN_W      = 16;
  localparam int FLOW_W     = 32;
  localparam int REL_W      = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MOD_BITS   = 4;
  localparam int MOD_CYCLES = ID_W / MOD_BITS;
  localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

  typedef enum logic [2:0] {
    OP_ADMIT  = 3'd0,
    OP_ACK    = 3'd1,
    OP_TICK   = 3'd2,
    OP_FINISH = 3'd3,
    OP_END    = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_REJECT = 2'd2,
    ST_IGNORE = 2'd3
  } status_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FLOW   = 2'd0,
    REG_WSIZE  = 2'd1,
    REG_MAXLEN = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADM_WAIT,
    S_SCAN,
    S_SCAN_PK,
    S_SCAN_CMP,
    S_REL_START,
    S_REL_WAIT,
    S_REL_RD,
    S_REL_CHK,
    S_DONE
  } state_e;

  // request to the modulo unit
  typedef struct packed {
    logic             start;
    logic [ID_W-1:0]  x;
    logic [CNT_W-1:0] w;
  } mod_req_t;

  // one restoring step: shift in a bit, subtract the divisor if it fits
  function automatic logic [IDX_W-1:0] mod_step(logic [IDX_W-1:0] r, logic b,
                                                logic [CNT_W-1:0] w);
    logic [IDX_W:0] t;
    t = {r, b};
    if (t >= (IDX_W+1)'(w)) begin
      t = t - (IDX_W+1)'(w);
    end
    return t[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

[src/sasw_if.sv]
// ----------------------------------------------------------------------------
// Selective ack send window channels
// Valid/ready channels for configuration, command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sasw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sasw_pkg::CFG_ADDR_W-1:0] addr;
  logic [sasw_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

interface sasw_in_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  opcode;
  logic [sasw_pkg::ID_W-1:0]   seq_id;
  logic [sasw_pkg::LEN_W-1:0]  payload_length;
  logic [sasw_pkg::FLOW_W-1:0] ack_flow;
  modport source (output valid, opcode, seq_id, payload_length, ack_flow,
                  input ready);
  modport sink (input valid, opcode, seq_id, payload_length, ack_flow,
                output ready);
endinterface

interface sasw_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [sasw_pkg::ID_W-1:0]   window_head;
  logic [sasw_pkg::ID_W-1:0]   next_segment;
  logic [sasw_pkg::CNT_W-1:0]  in_flight;
  logic [sasw_pkg::CNT_W-1:0]  high_water;
  logic [sasw_pkg::REL_W-1:0]  completed_count;
  logic                        end_sent;
  logic                        idle;
  modport source (output valid, status, window_head, next_segment, in_flight,
                  high_water, completed_count, end_sent, idle, input ready);
  modport sink (input valid, status, window_head, next_segment, in_flight,
                high_water, completed_count, end_sent, idle, output ready);
endinterface

`default_nettype wire

[src/sasw_ram.sv]
// ----------------------------------------------------------------------------
// Selective ack send window RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sasw_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[src/sasw_mod.sv]
// ----------------------------------------------------------------------------
// Selective ack send window modulo unit
// Reduces a 64-bit id modulo the window, four bits per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module sasw_mod (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sasw_pkg::mod_req_t        req_i,
  output logic                           done_o,
  output logic [sasw_pkg::IDX_W-1:0]     rem_o
);

  logic [sasw_pkg::ID_W-1:0]      x_q;
  logic [sasw_pkg::CNT_W-1:0]     w_q;
  logic [sasw_pkg::IDX_W-1:0]     r_q, r_d;
  logic [sasw_pkg::MOD_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;

  // four dependent restoring steps per cycle
  always_comb begin
    r_d = r_q;
    for (int j = 0; j < sasw_pkg::MOD_BITS; j++) begin
      r_d = sasw_pkg::mod_step(r_d, x_q[sasw_pkg::ID_W-1-j], w_q);
    end
  end

  // control: busy until the last digit step, pulse done at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + sasw_pkg::MOD_CNT_W'(1);
        if (cnt_q == sasw_pkg::MOD_CNT_W'(sasw_pkg::MOD_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: load operand, shift out digits, accumulate remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q <= req_i.x;
      w_q <= req_i.w;
      r_q <= '0;
    end else if (busy_q) begin
      x_q <= x_q << sasw_pkg::MOD_BITS;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

[src/selective_ack_send_window.sv]
// Result path: finish, try end, unknown words and early admit rejects go from
//   idle straight to the done state; a checked admit first waits for the modulo unit.
// Ack or tick: scan the slots, reading each unacked active one and matching it in
//   the pending ring, locate the base slot, then release acked segments in order.
// Throughput: one word at a time, the next is taken once the result is loaded.
// Reset: asynchronous active low; clears window state and valid bits and restores the configuration registers.
// ----------------------------------------------------------------------------
// Selective ack send window
// Sliding send window with selective acknowledgements held in a pending ring.
// ----------------------------------------------------------------------------
`default_nettype none
`include "selective_ack_send_window_defines.svh"

module selective_ack_send_window (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sasw_cfg_if.sink    cfg_i,
  sasw_in_if.sink     in_i,
  sasw_out_if.source  out_o
);

  localparam int WM = sasw_pkg::WINDOW_MAX;
  localparam int IW = sasw_pkg::IDX_W;
  localparam int CW = sasw_pkg::CNT_W;
  localparam int DW = sasw_pkg::ID_W;

  // configuration registers
  logic [sasw_pkg::FLOW_W-1:0] flow_q;
  logic [CW-1:0]               wsize_q;
  logic [sasw_pkg::LEN_W-1:0]  maxlen_q;

  // sequencer and window state
  sasw_pkg::state_e  state_q, state_d;
  sasw_pkg::status_e status_q, status_d;
  logic [DW-1:0]     id_q, id_d;
  logic [DW-1:0]     seg_q, seg_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     slot_q, slot_d;
  logic [DW-1:0]     base_q, base_d;
  logic [DW-1:0]     next_q, next_d;
  logic [CW-1:0]     total_q, total_d;
  logic [CW-1:0]     peak_q, peak_d;
  logic [sasw_pkg::REL_W-1:0] rel_q, rel_d;
  logic              indone_q, indone_d;
  logic              end_q, end_d;
  logic [WM-1:0]     active_q, active_d;
  logic [WM-1:0]     acked_q, acked_d;
  logic [WM-1:0]     pvalid_q, pvalid_d;

  // output register
  logic              ovalid_q, ovalid_d;
  sasw_pkg::status_e ostatus_q;
  logic [DW-1:0]     obase_q, onext_q;
  logic [CW-1:0]     oflight_q, ohigh_q;
  logic [sasw_pkg::REL_W-1:0] orel_q;
  logic              oend_q, oidle_q;
  logic              oload;

  // RAM ports
  logic          slot_we, pend_we;
  logic [IW-1:0] slot_waddr, slot_raddr, pend_waddr, pend_raddr;
  logic [DW-1:0] slot_wdata, slot_rdata, pend_wdata, pend_rdata;

  // modulo unit
  sasw_pkg::mod_req_t mod_req;
  logic               mod_done;
  logic [IW-1:0]      mod_rem;
  logic               mod_wait;

  logic          fire;
  logic [CW-1:0] weff;
  logic [DW-1:0] ack_dist;
  logic [DW-1:0] fill;
  logic [CW-1:0] slot_inc;

  assign weff     = (wsize_q > CW'(WM)) ? CW'(WM) : wsize_q;
  assign fire     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == sasw_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign ack_dist = in_i.seq_id - base_q;
  assign fill     = next_q - base_q;
  assign slot_inc = CW'(slot_q) + CW'(1);
  assign mod_wait = (state_q == sasw_pkg::S_ADM_WAIT) ||
                    (state_q == sasw_pkg::S_REL_WAIT);

  sasw_ram #(.DEPTH(WM), .WIDTH(DW)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  sasw_ram #(.DEPTH(WM), .WIDTH(DW)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (pend_wdata),
    .raddr_i (pend_raddr),
    .rdata_o (pend_rdata)
  );

  sasw_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  // sequencer: next state, state updates and RAM accesses
  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    id_d       = id_q;
    seg_d      = seg_q;
    idx_d      = idx_q;
    slot_d     = slot_q;
    base_d     = base_q;
    next_d     = next_q;
    total_d    = total_q;
    peak_d     = peak_q;
    rel_d      = rel_q;
    indone_d   = indone_q;
    end_d      = end_q;
    active_d   = active_q;
    acked_d    = acked_q;
    pvalid_d   = pvalid_q;
    slot_we    = 1'b0;
    slot_waddr = slot_q;
    slot_wdata = id_q;
    slot_raddr = slot_q;
    pend_we    = 1'b0;
    pend_waddr = in_i.seq_id[IW-1:0];
    pend_wdata = in_i.seq_id;
    pend_raddr = base_q[IW-1:0];
    mod_req.start = 1'b0;
    mod_req.x     = next_q;
    mod_req.w     = weff;
    oload      = 1'b0;
    ovalid_d   = ovalid_q && !out_o.ready;

    case (state_q)
      sasw_pkg::S_IDLE: begin
        if (fire) begin
          id_d  = in_i.seq_id;
          idx_d = '0;
          case (in_i.opcode)
            sasw_pkg::OP_ADMIT: begin
              state_d = sasw_pkg::S_DONE;
              if (in_i.payload_length == '0 || in_i.payload_length > maxlen_q) begin
                status_d = sasw_pkg::ST_REJECT;
              end else if (indone_q || weff == '0 || fill >= DW'(weff)) begin
                status_d = sasw_pkg::ST_FULL;
              end else begin
                mod_req.start = 1'b1;
                mod_req.x     = next_q;
                state_d       = sasw_pkg::S_ADM_WAIT;
              end
            end
            sasw_pkg::OP_ACK: begin
              if (in_i.ack_flow != flow_q) begin
                status_d = sasw_pkg::ST_IGNORE;
                state_d  = sasw_pkg::S_DONE;
              end else begin
                // keep an in-window ack in the pending ring
                if (in_i.seq_id >= base_q && ack_dist < DW'(weff)) begin
                  pend_we = 1'b1;
                  pvalid_d[in_i.seq_id[IW-1:0]] = 1'b1;
                end
                status_d = sasw_pkg::ST_DONE;
                state_d  = sasw_pkg::S_SCAN;
              end
            end
            sasw_pkg::OP_TICK: begin
              status_d = sasw_pkg::ST_DONE;
              state_d  = sasw_pkg::S_SCAN;
            end
            sasw_pkg::OP_FINISH: begin
              indone_d = 1'b1;
              status_d = sasw_pkg::ST_DONE;
              state_d  = sasw_pkg::S_DONE;
            end
            sasw_pkg::OP_END: begin
              if (end_q || !indone_q || total_q != '0) begin
                status_d = sasw_pkg::ST_IGNORE;
              end else begin
                end_d    = 1'b1;
                status_d = sasw_pkg::ST_DONE;
              end
              state_d = sasw_pkg::S_DONE;
            end
            default: begin
              status_d = sasw_pkg::ST_IGNORE;
              state_d  = sasw_pkg::S_DONE;
            end
          endcase
        end
      end

      // admit: target slot known, check and insert
      sasw_pkg::S_ADM_WAIT: begin
        if (mod_done) begin
          state_d = sasw_pkg::S_DONE;
          if (active_q[mod_rem]) begin
            status_d = sasw_pkg::ST_FULL;
          end else if (id_q != next_q) begin
            status_d = sasw_pkg::ST_REJECT;
          end else begin
            slot_we    = 1'b1;
            slot_waddr = mod_rem;
            active_d[mod_rem] = 1'b1;
            acked_d[mod_rem]  = 1'b0;
            next_d  = next_q + DW'(1);
            total_d = total_q + CW'(1);
            if (total_d > peak_q) begin
              peak_d = total_d;
            end
            status_d = sasw_pkg::ST_DONE;
          end
        end
      end

      // scan: pick the next unacked active slot and read its id
      sasw_pkg::S_SCAN: begin
        if (idx_q >= weff) begin
          state_d = sasw_pkg::S_REL_START;
        end else if (active_q[idx_q[IW-1:0]] && !acked_q[idx_q[IW-1:0]]) begin
          slot_raddr = idx_q[IW-1:0];
          state_d    = sasw_pkg::S_SCAN_PK;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      // scan: look up the pending ring entry for that id
      sasw_pkg::S_SCAN_PK: begin
        seg_d      = slot_rdata;
        pend_raddr = slot_rdata[IW-1:0];
        state_d    = sasw_pkg::S_SCAN_CMP;
      end

      // scan: mark the slot acked on a pending match
      sasw_pkg::S_SCAN_CMP: begin
        if (pvalid_q[seg_q[IW-1:0]] && pend_rdata == seg_q) begin
          acked_d[idx_q[IW-1:0]] = 1'b1;
        end
        idx_d   = idx_q + CW'(1);
        state_d = sasw_pkg::S_SCAN;
      end

      // release: locate the base slot
      sasw_pkg::S_REL_START: begin
        if (weff == '0 || total_q == '0) begin
          state_d = sasw_pkg::S_DONE;
        end else begin
          mod_req.start = 1'b1;
          mod_req.x     = base_q;
          state_d       = sasw_pkg::S_REL_WAIT;
        end
      end

      sasw_pkg::S_REL_WAIT: begin
        if (mod_done) begin
          slot_d  = mod_rem;
          state_d = sasw_pkg::S_REL_RD;
        end
      end

      // release: read base slot id and its pending entry
      sasw_pkg::S_REL_RD: begin
        if (total_q == '0) begin
          state_d = sasw_pkg::S_DONE;
        end else begin
          slot_raddr = slot_q;
          pend_raddr = base_q[IW-1:0];
          state_d    = sasw_pkg::S_REL_CHK;
        end
      end

      // release: free the base slot if acked, advance the base
      sasw_pkg::S_REL_CHK: begin
        if (active_q[slot_q] && acked_q[slot_q] && slot_rdata == base_q) begin
          if (pvalid_q[base_q[IW-1:0]] && pend_rdata == base_q) begin
            pvalid_d[base_q[IW-1:0]] = 1'b0;
          end
          active_d[slot_q] = 1'b0;
          acked_d[slot_q]  = 1'b0;
          total_d = total_q - CW'(1);
          if (rel_q != '1) begin
            rel_d = rel_q + sasw_pkg::REL_W'(1);
          end
          base_d  = base_q + DW'(1);
          slot_d  = (slot_inc == weff) ? '0 : slot_inc[IW-1:0];
          state_d = sasw_pkg::S_REL_RD;
        end else begin
          state_d = sasw_pkg::S_DONE;
        end
      end

      // hand the result word to the output register
      sasw_pkg::S_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          oload    = 1'b1;
          ovalid_d = 1'b1;
          state_d  = sasw_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = sasw_pkg::S_IDLE;
      end
    endcase
  end

  // state register and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sasw_pkg::S_IDLE;
      base_q   <= '0;
      next_q   <= '0;
      total_q  <= '0;
      peak_q   <= '0;
      rel_q    <= '0;
      indone_q <= 1'b0;
      end_q    <= 1'b0;
      active_q <= '0;
      acked_q  <= '0;
      pvalid_q <= '0;
      ovalid_q <= 1'b0;
      flow_q   <= '0;
      wsize_q  <= CW'(16);
      maxlen_q <= '1;
    end else begin
      state_q  <= state_d;
      base_q   <= base_d;
      next_q   <= next_d;
      total_q  <= total_d;
      peak_q   <= peak_d;
      rel_q    <= rel_d;
      indone_q <= indone_d;
      end_q    <= end_d;
      active_q <= active_d;
      acked_q  <= acked_d;
      pvalid_q <= pvalid_d;
      ovalid_q <= ovalid_d;
      // configuration writes
      if (cfg_i.valid) begin
        case (cfg_i.addr)
          sasw_pkg::REG_FLOW:   flow_q   <= cfg_i.data;
          sasw_pkg::REG_WSIZE:  wsize_q  <= cfg_i.data[CW-1:0];
          sasw_pkg::REG_MAXLEN: maxlen_q <= cfg_i.data[sasw_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // item and scratch registers, no reset needed
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    id_q     <= id_d;
    seg_q    <= seg_d;
    idx_q    <= idx_d;
    slot_q   <= slot_d;
    if (oload) begin
      ostatus_q <= status_q;
      obase_q   <= base_q;
      onext_q   <= next_q;
      oflight_q <= total_q;
      ohigh_q   <= peak_q;
      orel_q    <= rel_q;
      oend_q    <= end_q;
      oidle_q   <= indone_q && (total_q == '0);
    end
  end

  assign out_o.valid           = ovalid_q;
  assign out_o.status          = ostatus_q;
  assign out_o.window_head     = obase_q;
  assign out_o.next_segment    = onext_q;
  assign out_o.in_flight       = oflight_q;
  assign out_o.high_water      = ohigh_q;
  assign out_o.completed_count = orel_q;
  assign out_o.end_sent        = oend_q;
  assign out_o.idle            = oidle_q;

  `SASW_ASSERT(a_total_matches_active, $countones(active_q) == int'(total_q))
  `SASW_ASSERT(a_peak_covers_total, peak_q >= total_q)
  `SASW_ASSERT(a_mod_done_waited, mod_done |-> mod_wait)
  `SASW_NEVER(a_acked_only_active, |(acked_q & ~active_q))

endmodule

`default_nettype wire

[test/selective_ack_send_window_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Selective ack send window checker
// Watches the config, command and result channels, predicts one result word
// per accepted command word and compares it field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_ack_send_window_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  sasw_cfg_if                            cfg_mon,
  sasw_in_if                             in_mon,
  sasw_out_if                            out_mon,
  output int unsigned                    fail_count_o,
  output int unsigned                    waiting_o,
  output logic [sasw_pkg::ID_W-1:0]      base_o,
  output logic [sasw_pkg::ID_W-1:0]      next_o
);

  typedef struct packed {
    logic [1:0]                 status;
    logic [sasw_pkg::ID_W-1:0]  window_head;
    logic [sasw_pkg::ID_W-1:0]  next_segment;
    logic [sasw_pkg::CNT_W-1:0] in_flight;
    logic [sasw_pkg::CNT_W-1:0] high_water;
    logic [sasw_pkg::REL_W-1:0] completed_count;
    logic                       end_sent;
    logic                       idle;
  } window_report_t;

  // shadow registers
  logic [sasw_pkg::FLOW_W-1:0] flow_r;
  logic [4:0]                  wsize_r;
  logic [sasw_pkg::LEN_W-1:0]  maxlen_r;

  // shadow window state
  logic                        act_q  [sasw_pkg::WINDOW_MAX];
  logic                        ackd_q [sasw_pkg::WINDOW_MAX];
  logic [sasw_pkg::ID_W-1:0]   seg_q  [sasw_pkg::WINDOW_MAX];
  logic [sasw_pkg::ID_W-1:0]   pid_q  [sasw_pkg::WINDOW_MAX];
  logic                        pval_q [sasw_pkg::WINDOW_MAX];
  logic [sasw_pkg::ID_W-1:0]   base_q, next_q;
  int unsigned                 active_n, peak_n;
  logic [sasw_pkg::REL_W-1:0]  released_n;
  logic                        fin_q, end_q;

  window_report_t    report_fifo[$];
  int unsigned       fails;

  assign fail_count_o = fails;
  assign waiting_o    = report_fifo.size();

  function automatic int unsigned live_window();
    return (wsize_r > sasw_pkg::WINDOW_MAX) ? sasw_pkg::WINDOW_MAX : int'(wsize_r);
  endfunction

  function automatic logic ack_held(logic [sasw_pkg::ID_W-1:0] id);
    return pval_q[id[sasw_pkg::IDX_W-1:0]] && (pid_q[id[sasw_pkg::IDX_W-1:0]] == id);
  endfunction

  // mark acked slots, then free acked segments at the base in order
  task automatic sweep_acks();
    int unsigned w;
    int unsigned s;
    w = live_window();
    for (int i = 0; i < w; i++) begin
      if (act_q[i] && !ackd_q[i] && ack_held(seg_q[i])) ackd_q[i] = 1'b1;
    end
    while (w != 0 && active_n > 0) begin
      s = int'(base_q % w);
      if (!act_q[s] || seg_q[s] != base_q || !ackd_q[s]) break;
      if (ack_held(base_q)) pval_q[base_q[sasw_pkg::IDX_W-1:0]] = 1'b0;
      act_q[s]  = 1'b0;
      ackd_q[s] = 1'b0;
      active_n--;
      if (released_n != '1) released_n++;
      base_q++;
    end
  endtask

  task automatic try_admit(logic [sasw_pkg::ID_W-1:0] id,
                           logic [sasw_pkg::LEN_W-1:0] len,
                           output sasw_pkg::status_e st);
    int unsigned w;
    int unsigned s;
    w = live_window();
    if (len == 0 || len > maxlen_r) begin
      st = sasw_pkg::ST_REJECT;
      return;
    end
    if (fin_q || w == 0 || (next_q - base_q) >= 64'(w)) begin
      st = sasw_pkg::ST_FULL;
      return;
    end
    s = int'(next_q % w);
    if (act_q[s]) begin
      st = sasw_pkg::ST_FULL;
      return;
    end
    if (id != next_q) begin
      st = sasw_pkg::ST_REJECT;
      return;
    end
    act_q[s]  = 1'b1;
    ackd_q[s] = 1'b0;
    seg_q[s]  = id;
    next_q++;
    active_n++;
    if (active_n > peak_n) peak_n = active_n;
    st = sasw_pkg::ST_DONE;
  endtask

  task automatic predict_report(logic [2:0] op, logic [sasw_pkg::ID_W-1:0] id,
                                logic [sasw_pkg::LEN_W-1:0] len,
                                logic [sasw_pkg::FLOW_W-1:0] fl,
                                output window_report_t rep);
    sasw_pkg::status_e st;
    case (op)
      sasw_pkg::OP_ADMIT: try_admit(id, len, st);
      sasw_pkg::OP_ACK: begin
        if (fl != flow_r) begin
          st = sasw_pkg::ST_IGNORE;
        end else begin
          if (id >= base_q && (id - base_q) < 64'(live_window())) begin
            pid_q[id[sasw_pkg::IDX_W-1:0]]  = id;
            pval_q[id[sasw_pkg::IDX_W-1:0]] = 1'b1;
          end
          sweep_acks();
          st = sasw_pkg::ST_DONE;
        end
      end
      sasw_pkg::OP_TICK: begin
        sweep_acks();
        st = sasw_pkg::ST_DONE;
      end
      sasw_pkg::OP_FINISH: begin
        fin_q = 1'b1;
        st = sasw_pkg::ST_DONE;
      end
      sasw_pkg::OP_END: begin
        if (end_q || !fin_q || active_n != 0) begin
          st = sasw_pkg::ST_IGNORE;
        end else begin
          end_q = 1'b1;
          st = sasw_pkg::ST_DONE;
        end
      end
      default: st = sasw_pkg::ST_IGNORE;
    endcase
    rep.status          = st;
    rep.window_head     = base_q;
    rep.next_segment    = next_q;
    rep.in_flight       = sasw_pkg::CNT_W'(active_n);
    rep.high_water      = sasw_pkg::CNT_W'(peak_n);
    rep.completed_count = released_n;
    rep.end_sent        = end_q;
    rep.idle            = fin_q && (active_n == 0);
  endtask

  task automatic compare_report(window_report_t want, window_report_t got);
    logic [sasw_pkg::ID_W-1:0] wv [8];
    logic [sasw_pkg::ID_W-1:0] gv [8];
    string                     fname [8];
    fname = '{"status", "window_head", "next_segment", "in_flight",
              "high_water", "completed_count", "end_sent", "idle"};
    wv = '{64'(want.status), want.window_head, want.next_segment,
           64'(want.in_flight), 64'(want.high_water), 64'(want.completed_count),
           64'(want.end_sent), 64'(want.idle)};
    gv = '{64'(got.status), got.window_head, got.next_segment,
           64'(got.in_flight), 64'(got.high_water), 64'(got.completed_count),
           64'(got.end_sent), 64'(got.idle)};
    for (int i = 0; i < 8; i++) begin
      if (wv[i] !== gv[i]) begin
        fails++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname[i],
                 wv[i], gv[i]);
      end
    end
  endtask

  // observe all channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    window_report_t rep;
    window_report_t got;
    if (!rst_ni) begin
      flow_r     = '0;
      wsize_r    = 5'd16;
      maxlen_r   = '1;
      for (int i = 0; i < sasw_pkg::WINDOW_MAX; i++) begin
        act_q[i]  = 1'b0;
        ackd_q[i] = 1'b0;
        pval_q[i] = 1'b0;
      end
      base_q     = '0;
      next_q     = '0;
      active_n   = 0;
      peak_n     = 0;
      released_n = '0;
      fin_q      = 1'b0;
      end_q      = 1'b0;
      fails      = 0;
      report_fifo.delete();
    end else begin
      // retire the result word first
      if (out_mon.valid && out_mon.ready) begin
        got.status          = out_mon.status;
        got.window_head     = out_mon.window_head;
        got.next_segment    = out_mon.next_segment;
        got.in_flight       = out_mon.in_flight;
        got.high_water      = out_mon.high_water;
        got.completed_count = out_mon.completed_count;
        got.end_sent        = out_mon.end_sent;
        got.idle            = out_mon.idle;
        if (report_fifo.size() == 0) begin
          fails++;
          $display("%0t: result word with none expected: expected none, actual %h",
                   $time, got);
        end else begin
          compare_report(report_fifo.pop_front(), got);
        end
      end
      // register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.addr)
          sasw_pkg::REG_FLOW:   flow_r   = cfg_mon.data[sasw_pkg::FLOW_W-1:0];
          sasw_pkg::REG_WSIZE:  wsize_r  = cfg_mon.data[4:0];
          sasw_pkg::REG_MAXLEN: maxlen_r = cfg_mon.data[sasw_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      // command words
      if (in_mon.valid && in_mon.ready) begin
        predict_report(in_mon.opcode, in_mon.seq_id, in_mon.payload_length,
                       in_mon.ack_flow, rep);
        report_fifo.push_back(rep);
      end
    end
    base_o <= base_q;
    next_o <= next_q;
  end

endmodule

`default_nettype wire

[test/selective_ack_send_window_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Selective ack send window testbench
// Drives directed and random command words through several register settings,
// stalls both sides at random and leaves checking to the checker module.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_ack_send_window_test;

  localparam logic [sasw_pkg::CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
  localparam logic [2:0] OP_BAD5 = 3'd5;
  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 270;

  logic clk_i = 1'b0;
  logic rst_ni;

  sasw_cfg_if cfg_bus ();
  sasw_in_if  cmd_bus ();
  sasw_out_if rsp_bus ();

  int unsigned               fail_count, waiting;
  logic [sasw_pkg::ID_W-1:0] win_base, win_next;

  logic                        quiet = 1'b0;
  logic                        hold_req = 1'b0;
  int unsigned                 stall_left = 0;
  int unsigned                 cycles = 0;
  logic [sasw_pkg::FLOW_W-1:0] cur_flow = '0;
  logic [sasw_pkg::LEN_W-1:0]  cur_maxlen = '1;

  selective_ack_send_window uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (cmd_bus),
    .out_o  (rsp_bus)
  );

  selective_ack_send_window_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_bus),
    .in_mon       (cmd_bus),
    .out_mon      (rsp_bus),
    .fail_count_o (fail_count),
    .waiting_o    (waiting),
    .base_o       (win_base),
    .next_o       (win_next)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("selective_ack_send_window_test failed");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        rsp_bus.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        hold_req = 1'b0;
        rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // offer one command word and hold it until accepted
  task automatic send_word(logic [2:0] op, logic [sasw_pkg::ID_W-1:0] id,
                           logic [sasw_pkg::LEN_W-1:0] len,
                           logic [sasw_pkg::FLOW_W-1:0] fl);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    cmd_bus.valid          <= 1'b1;
    cmd_bus.opcode         <= op;
    cmd_bus.seq_id         <= id;
    cmd_bus.payload_length <= len;
    cmd_bus.ack_flow       <= fl;
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  // write a register once the block has drained
  task automatic write_reg(logic [sasw_pkg::CFG_ADDR_W-1:0] addr,
                           logic [sasw_pkg::CFG_DATA_W-1:0] data);
    cmd_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= addr;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [sasw_pkg::LEN_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return (cur_maxlen == '1) ? cur_maxlen : cur_maxlen + 1'b1;
      2:       return sasw_pkg::LEN_W'($urandom);
      3:       return cur_maxlen;
      default: return sasw_pkg::LEN_W'($urandom_range(1, int'(cur_maxlen)));
    endcase
  endfunction

  // mostly well-formed traffic; the rest is noise
  task automatic random_word();
    logic [sasw_pkg::ID_W-1:0]   rid;
    logic [sasw_pkg::FLOW_W-1:0] rfl;
    int unsigned                 pick;
    rid  = {$urandom, $urandom};
    rfl  = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_word(sasw_pkg::OP_ADMIT, win_next + 64'($urandom_range(0, 1)), pick_len(),
                rfl);
    end else if (pick < 75) begin
      send_word(sasw_pkg::OP_ACK, win_base + 64'($urandom_range(0, 17)),
                sasw_pkg::LEN_W'($urandom),
                ($urandom_range(0, 9) == 0) ? rfl : cur_flow);
    end else if (pick < 85) begin
      send_word(sasw_pkg::OP_TICK, rid, sasw_pkg::LEN_W'($urandom), rfl);
    end else if (pick < 89) begin
      send_word(sasw_pkg::OP_END, rid, sasw_pkg::LEN_W'($urandom), rfl);
    end else if (pick < 93) begin
      send_word(sasw_pkg::OP_ADMIT, rid, sasw_pkg::LEN_W'($urandom), rfl);
    end else if (pick < 97) begin
      send_word(sasw_pkg::OP_ACK, rid, sasw_pkg::LEN_W'($urandom), rfl);
    end else begin
      send_word(3'($urandom_range(5, 7)), rid, sasw_pkg::LEN_W'($urandom), rfl);
    end
  endtask

  initial begin
    logic [sasw_pkg::FLOW_W-1:0] flows  [PHASES];
    logic [4:0]                  wsizes [PHASES];
    logic [sasw_pkg::LEN_W-1:0]  lens   [PHASES];
    flows  = '{32'hFFFF_FFFF, 32'h0, 32'h5A5A_A5A5, 32'h1234_5678, 32'h0, 32'h8000_0001};
    wsizes = '{5'd1, 5'd31, 5'd0, 5'd5, 5'd16, 5'd16};
    lens   = '{16'd1, 16'hFFFF, 16'd100, 16'd1000, 16'd1, 16'hFFFF};

    rst_ni                  <= 1'b0;
    cfg_bus.valid           <= 1'b0;
    cfg_bus.addr            <= '0;
    cfg_bus.data            <= '0;
    cmd_bus.valid           <= 1'b0;
    cmd_bus.opcode          <= '0;
    cmd_bus.seq_id          <= '0;
    cmd_bus.payload_length  <= '0;
    cmd_bus.ack_flow        <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, field extremes, every opcode but finish
    send_word(sasw_pkg::OP_ADMIT, 64'd0, 16'd0, 32'h0);
    send_word(sasw_pkg::OP_ADMIT, '1, 16'hFFFF, 32'h0);
    send_word(sasw_pkg::OP_ADMIT, 64'd0, 16'hFFFF, 32'h0);
    send_word(sasw_pkg::OP_ADMIT, 64'd1, 16'd1, 32'h0);
    send_word(sasw_pkg::OP_ACK, 64'd1, 16'd0, 32'hFFFF_FFFF);
    send_word(sasw_pkg::OP_ACK, 64'd1, 16'd0, 32'h0);
    send_word(sasw_pkg::OP_ACK, 64'd40, 16'd0, 32'h0);
    send_word(sasw_pkg::OP_ACK, '1, 16'hFFFF, 32'h0);
    send_word(sasw_pkg::OP_TICK, 64'd0, 16'd0, 32'h0);
    send_word(sasw_pkg::OP_ACK, 64'd0, 16'd0, 32'h0);
    send_word(OP_BAD5, '1, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(OP_BAD6, 64'd0, 16'd0, 32'h0);
    send_word(OP_BAD7, 64'd2, 16'd1, 32'h0);
    send_word(sasw_pkg::OP_END, 64'd0, 16'd0, 32'h0);
    // fill the window and overflow it by one
    for (int i = 2; i < 19; i++) send_word(sasw_pkg::OP_ADMIT, 64'(i), 16'd7, 32'h0);
    send_word(sasw_pkg::OP_ACK, 64'd3, 16'd0, 32'h0);

    // long result hold-off while commands keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) random_word();

    // random phases under different register settings
    for (int p = 0; p < PHASES; p++) begin
      write_reg(sasw_pkg::REG_FLOW, flows[p]);
      write_reg(sasw_pkg::REG_WSIZE, sasw_pkg::CFG_DATA_W'(wsizes[p]));
      write_reg(sasw_pkg::REG_MAXLEN, sasw_pkg::CFG_DATA_W'(lens[p]));
      if (p == 2) write_reg(REG_SPARE, '1);
      cur_flow   = flows[p];
      cur_maxlen = lens[p];
      for (int i = 0; i < PHASE_ITEMS; i++) random_word();
    end

    // closing part without idling: drain, finish, end marker
    quiet = 1'b1;
    for (int i = 0; i < 60; i++) random_word();
    send_word(sasw_pkg::OP_END, 64'd0, 16'd0, cur_flow);
    for (int i = 0; i < sasw_pkg::WINDOW_MAX; i++) begin
      send_word(sasw_pkg::OP_ACK, win_base + 64'(i), 16'd0, cur_flow);
    end
    send_word(sasw_pkg::OP_TICK, 64'd0, 16'd0, cur_flow);
    send_word(sasw_pkg::OP_FINISH, 64'd0, 16'd0, cur_flow);
    send_word(sasw_pkg::OP_ADMIT, win_next, 16'd1, cur_flow);
    send_word(sasw_pkg::OP_END, 64'd0, 16'd0, cur_flow);
    for (int i = 0; i < sasw_pkg::WINDOW_MAX; i++) begin
      send_word(sasw_pkg::OP_ACK, win_base + 64'(i), 16'd0, cur_flow);
    end
    send_word(sasw_pkg::OP_END, 64'd0, 16'd0, cur_flow);
    send_word(sasw_pkg::OP_END, 64'd0, 16'd0, cur_flow);
    send_word(sasw_pkg::OP_FINISH, 64'd0, 16'd0, cur_flow);
    cmd_bus.valid <= 1'b0;

    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("selective_ack_send_window_test passed");
    end else begin
      $display("selective_ack_send_window_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
